FILE: design/cpwq_pkg.sv
// ----------------------------------------------------------------------------
// cpwq_pkg
// Shared types, widths and codes for the coin pulse width qualifier.
// ----------------------------------------------------------------------------
package cpwq_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int MS_W      = 16;
  localparam int PORT_W    = 8;
  localparam int BIT_SEL_W = 3;
  localparam int OUTC_W    = 3;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COIN_BIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_QUIET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REARM_QUIET   = 3'd6;

  // Register reset values
  localparam logic [BIT_SEL_W-1:0] COIN_BIT_RST  = 3'd6;
  localparam logic [MS_W-1:0]      MAX_PULSE_RST = 16'hFFFF;

  // Qualifier modes
  localparam logic [MODE_W-1:0] MODE_ARMING = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PULSE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REARM  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FAULT  = 3'd4;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUT_NONE     = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_ACCEPT   = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_SHORT    = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_COOLDOWN = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_STUCK    = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_IGNORED  = 3'd5;

  // Configuration register set
  typedef struct packed {
    logic [BIT_SEL_W-1:0] coin_bit;
    logic [MS_W-1:0]      startup_delay_ms;
    logic [MS_W-1:0]      startup_quiet_ms;
    logic [MS_W-1:0]      min_pulse_ms;
    logic [MS_W-1:0]      max_pulse_ms;
    logic [MS_W-1:0]      cooldown_ms;
    logic [MS_W-1:0]      rearm_quiet_ms;
  } cfg_t;

  // One poll sample
  typedef struct packed {
    logic              sample_valid;
    logic [PORT_W-1:0] port_value;
    logic [TIME_W-1:0] time_ms;
  } sample_t;

  // One result
  typedef struct packed {
    logic               coin_detected;
    logic [OUTC_W-1:0]  outcome;
    logic [MODE_W-1:0]  detector_mode;
    logic [COUNT_W-1:0] coin_total;
  } result_t;

endpackage

FILE: design/cpwq_ifs.sv
// ----------------------------------------------------------------------------
// cpwq channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------

// Sample channel
interface cpwq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          sample_valid;
  logic [cpwq_pkg::PORT_W-1:0]   port_value;
  logic [cpwq_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, sample_valid, port_value, time_ms, input ready);
  modport sink   (input valid, sample_valid, port_value, time_ms, output ready);
endinterface

// Result channel
interface cpwq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          coin_detected;
  logic [cpwq_pkg::OUTC_W-1:0]   outcome;
  logic [cpwq_pkg::MODE_W-1:0]   detector_mode;
  logic [cpwq_pkg::COUNT_W-1:0]  coin_total;

  modport source (output valid, coin_detected, outcome, detector_mode, coin_total,
                  input ready);
  modport sink   (input valid, coin_detected, outcome, detector_mode, coin_total,
                  output ready);
endinterface

// Register write channel
interface cpwq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpwq_pkg::CFG_IDX_W-1:0] index;
  logic [cpwq_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/cpwq_cfg_regs.sv
// ----------------------------------------------------------------------------
// cpwq_cfg_regs
// Configuration register file, written over the register write channel.
// ----------------------------------------------------------------------------
module cpwq_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  cpwq_cfg_if.sink         cfg_if,
  output cpwq_pkg::cfg_t   cfg
);
  import cpwq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  // Writes are always taken
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid;

  // Register decode; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_if.index)
        REG_COIN_BIT:      cfg_nxt.coin_bit         = cfg_if.data[BIT_SEL_W-1:0];
        REG_STARTUP_DELAY: cfg_nxt.startup_delay_ms = cfg_if.data[MS_W-1:0];
        REG_STARTUP_QUIET: cfg_nxt.startup_quiet_ms = cfg_if.data[MS_W-1:0];
        REG_MIN_PULSE:     cfg_nxt.min_pulse_ms     = cfg_if.data[MS_W-1:0];
        REG_MAX_PULSE:     cfg_nxt.max_pulse_ms     = cfg_if.data[MS_W-1:0];
        REG_COOLDOWN:      cfg_nxt.cooldown_ms      = cfg_if.data[MS_W-1:0];
        REG_REARM_QUIET:   cfg_nxt.rearm_quiet_ms   = cfg_if.data[MS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coin_bit         <= COIN_BIT_RST;
      cfg_r.startup_delay_ms <= '0;
      cfg_r.startup_quiet_ms <= '0;
      cfg_r.min_pulse_ms     <= '0;
      cfg_r.max_pulse_ms     <= MAX_PULSE_RST;
      cfg_r.cooldown_ms      <= '0;
      cfg_r.rearm_quiet_ms   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/cpwq_core.sv
// ----------------------------------------------------------------------------
// cpwq_core
// Qualifier state machine: mode, timing marks and coin counter, with the
// single-pass decision for one registered sample.
// ----------------------------------------------------------------------------
module cpwq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  cpwq_pkg::cfg_t      cfg,
  input  cpwq_pkg::sample_t   sample,
  input  logic                step,
  output cpwq_pkg::result_t   result
);
  import cpwq_pkg::*;

  logic [MODE_W-1:0]  mode_r,           mode_nxt;
  logic [TIME_W-1:0]  quiet_start_r,    quiet_start_nxt;
  logic               quiet_started_r,  quiet_started_nxt;
  logic [TIME_W-1:0]  pulse_start_r,    pulse_start_nxt;
  logic [TIME_W-1:0]  last_coin_r,      last_coin_nxt;
  logic               coin_seen_r,      coin_seen_nxt;
  logic [COUNT_W-1:0] coin_count_r,     coin_count_nxt;

  logic [TIME_W-1:0]  now;
  logic [TIME_W-1:0]  el_quiet;
  logic [TIME_W-1:0]  el_pulse;
  logic [TIME_W-1:0]  el_coin;
  logic               ignore;
  logic               high;
  logic [OUTC_W-1:0]  outcome;
  logic               detected;

  // Wrapping time differences
  assign now      = sample.time_ms;
  assign el_quiet = now - quiet_start_r;
  assign el_pulse = now - pulse_start_r;
  assign el_coin  = now - last_coin_r;

  assign ignore = !sample.sample_valid ||
                  (now < {{(TIME_W-MS_W){1'b0}}, cfg.startup_delay_ms});
  assign high   = sample.port_value[cfg.coin_bit];

  // Next state and outcome
  always_comb begin
    mode_nxt          = mode_r;
    quiet_start_nxt   = quiet_start_r;
    quiet_started_nxt = quiet_started_r;
    pulse_start_nxt   = pulse_start_r;
    last_coin_nxt     = last_coin_r;
    coin_seen_nxt     = coin_seen_r;
    coin_count_nxt    = coin_count_r;
    outcome           = OUT_NONE;
    detected          = 1'b0;
    if (ignore) begin
      outcome = OUT_IGNORED;
    end else begin
      unique case (mode_r)
        MODE_ARMING: begin
          if (high) begin
            quiet_started_nxt = 1'b0;
          end else if (!quiet_started_r) begin
            quiet_start_nxt   = now;
            quiet_started_nxt = 1'b1;
          end else if (el_quiet >= {{(TIME_W-MS_W){1'b0}}, cfg.startup_quiet_ms}) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          if (high) begin
            pulse_start_nxt = now;
            mode_nxt        = MODE_PULSE;
          end
        end
        MODE_PULSE: begin
          if (high) begin
            // stuck line
            if (el_pulse > {{(TIME_W-MS_W){1'b0}}, cfg.max_pulse_ms}) begin
              mode_nxt = MODE_FAULT;
              outcome  = OUT_STUCK;
            end
          end else begin
            if (el_pulse < {{(TIME_W-MS_W){1'b0}}, cfg.min_pulse_ms}) begin
              outcome = OUT_SHORT;
            end else if (coin_seen_r &&
                         (el_coin < {{(TIME_W-MS_W){1'b0}}, cfg.cooldown_ms})) begin
              outcome = OUT_COOLDOWN;
            end else begin
              outcome        = OUT_ACCEPT;
              detected       = 1'b1;
              coin_count_nxt = coin_count_r + 1'b1;
              last_coin_nxt  = now;
              coin_seen_nxt  = 1'b1;
            end
            quiet_start_nxt   = now;
            quiet_started_nxt = 1'b1;
            mode_nxt          = MODE_REARM;
          end
        end
        MODE_REARM: begin
          if (high) begin
            quiet_start_nxt   = now;
            quiet_started_nxt = 1'b1;
          end else if (el_quiet >= {{(TIME_W-MS_W){1'b0}}, cfg.rearm_quiet_ms}) begin
            mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          // fault: leave once the line drops
          if (!high) begin
            quiet_start_nxt   = now;
            quiet_started_nxt = 1'b1;
            mode_nxt          = MODE_REARM;
          end
        end
      endcase
    end
  end

  // State update on each sample taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_ARMING;
      quiet_start_r   <= '0;
      quiet_started_r <= 1'b0;
      pulse_start_r   <= '0;
      last_coin_r     <= '0;
      coin_seen_r     <= 1'b0;
      coin_count_r    <= '0;
    end else if (step) begin
      mode_r          <= mode_nxt;
      quiet_start_r   <= quiet_start_nxt;
      quiet_started_r <= quiet_started_nxt;
      pulse_start_r   <= pulse_start_nxt;
      last_coin_r     <= last_coin_nxt;
      coin_seen_r     <= coin_seen_nxt;
      coin_count_r    <= coin_count_nxt;
    end
  end

  assign result.coin_detected = detected;
  assign result.outcome       = outcome;
  assign result.detector_mode = mode_nxt;
  assign result.coin_total    = coin_count_nxt;

endmodule

FILE: design/coin_pulse_width_qualifier.sv
// ----------------------------------------------------------------------------
// coin_pulse_width_qualifier
// Qualifies coin pulses on one bit of a polled port: width window, stuck
// fault, cooldown and rearm, with an accepted-coin counter.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  in_if   | in  | valid / ready | sample_valid, port_value, time_ms
//  out_if  | out | valid / ready | coin_detected, outcome, detector_mode,
//          |     |               | coin_total
//  cfg_if  | in  | valid / ready | index, data (ready always high)
//
//  One request per clock sustained while out_if does not stall; a request
//  goes through the sample register, then the result register, to out_if.
//  The qualifier state is updated as the result register is loaded.
//  Reset is synchronous, active low; it restores the register defaults and
//  puts the qualifier in arming with the counter at zero.
//  A stall on out_if holds the result; the sample register still takes one
//  more request behind it, and in_if.ready drops only when both are full.
// ----------------------------------------------------------------------------
module coin_pulse_width_qualifier (
  input  logic        clk,
  input  logic        rst_n,
  cpwq_cfg_if.sink    cfg_if,
  cpwq_in_if.sink     in_if,
  cpwq_out_if.source  out_if
);
  import cpwq_pkg::*;

  cfg_t    cfg;
  sample_t smp_r;
  logic    smp_valid_r, smp_valid_nxt;
  result_t res;
  result_t res_r;
  logic    res_valid_r, res_valid_nxt;
  logic    in_fire;
  logic    advance;

  cpwq_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Handshake control
  assign advance     = smp_valid_r && (!res_valid_r || out_if.ready);
  assign in_if.ready = !smp_valid_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  always_comb begin
    smp_valid_nxt = smp_valid_r;
    if (in_fire) begin
      smp_valid_nxt = 1'b1;
    end else if (advance) begin
      smp_valid_nxt = 1'b0;
    end
    res_valid_nxt = res_valid_r;
    if (advance) begin
      res_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      smp_valid_r <= smp_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Sample register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r.sample_valid <= in_if.sample_valid;
      smp_r.port_value   <= in_if.port_value;
      smp_r.time_ms      <= in_if.time_ms;
    end
  end

  cpwq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .sample (smp_r),
    .step   (advance),
    .result (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_if.valid         = res_valid_r;
  assign out_if.coin_detected = res_r.coin_detected;
  assign out_if.outcome       = res_r.outcome;
  assign out_if.detector_mode = res_r.detector_mode;
  assign out_if.coin_total    = res_r.coin_total;

endmodule

FILE: design/cpwq_checker.sv
// ----------------------------------------------------------------------------
// cpwq_checker
// Port-level checks on the qualifier's result channel.
// ----------------------------------------------------------------------------
module cpwq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          coin_detected,
  input logic [cpwq_pkg::OUTC_W-1:0]   outcome,
  input logic [cpwq_pkg::MODE_W-1:0]   detector_mode,
  input logic [cpwq_pkg::COUNT_W-1:0]  coin_total
);
  import cpwq_pkg::*;

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(coin_total) &&
                                   $stable(outcome)))
    else $error("result changed while stalled");

  // A detected coin is reported as accepted
  a_detect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && coin_detected) |-> (outcome == OUT_ACCEPT))
    else $error("coin flag without accept outcome");

  // A stuck pulse lands in fault
  a_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && outcome == OUT_STUCK) |-> (detector_mode == MODE_FAULT))
    else $error("stuck outcome outside fault");

  // Any pulse end goes to rearm
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (outcome == OUT_ACCEPT || outcome == OUT_SHORT ||
                   outcome == OUT_COOLDOWN)) |-> (detector_mode == MODE_REARM))
    else $error("pulse end outside rearm");

endmodule

bind coin_pulse_width_qualifier cpwq_checker u_cpwq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .coin_detected (out_if.coin_detected),
  .outcome       (out_if.outcome),
  .detector_mode (out_if.detector_mode),
  .coin_total    (out_if.coin_total)
);
